>>> design/afr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package afr_pkg;

    localparam int CNT_W   = 11;
    localparam int QDEPTH  = 4;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_POP    = 2'd2,
        KIND_EMPTY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FMT_PCM16 = 2'd0,
        FMT_PCM24 = 2'd1,
        FMT_PCM32 = 2'd2,
        FMT_FLT32 = 2'd3
    } fmt_t;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_CAPACITY = 2'd1;

    localparam logic [3:0]       CH_RESET  = 4'd2;
    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    // one job from the front to the converter
    typedef struct packed {
        kind_t            kind;
        logic [31:0]      raw;
        fmt_t             fmt;
        logic [2:0]       flags;
        logic             last;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] peak;
    } job_t;

    // one finished result
    typedef struct packed {
        kind_t            kind;
        logic [31:0]      sample;
        logic [2:0]       flags;
        logic             last;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] peak;
    } res_t;

endpackage
`default_nettype wire

>>> design/afr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module afr_queue
    import afr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_data,
    output logic      push_ready,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      pop_valid
);
    localparam int PW = $clog2(QDEPTH);

    job_t          mem_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign push_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && push_ready)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop && pop_valid)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push && push_ready) - (PW+1)'(pop && pop_valid);
        end
    end
endmodule
`default_nettype wire

>>> design/afr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module afr_front
    import afr_pkg::*;
#(
    parameter int FRAME_DEPTH  = 1024,
    parameter int MAX_CHANNELS = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_idx,
    input  wire logic [CNT_W-1:0] cfg_val,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             cmd,
    input  wire logic [31:0]      raw,
    input  wire logic [1:0]       fmt,
    input  wire logic [2:0]       flg,
    input  wire logic [CNT_W-1:0] plen,
    input  wire logic             first,
    input  wire logic             last,
    output logic                  q_push,
    output job_t                  q_data,
    input  wire logic             q_ready
);
    localparam int IW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int AW    = $clog2(FRAME_DEPTH * MAX_CHANNELS);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHC_W = $clog2(MAX_CHANNELS + 1);

    typedef enum logic [1:0] { S_IDLE, S_RD, S_WR } state_t;

    logic [31:0] sample_mem [FRAME_DEPTH * MAX_CHANNELS];
    logic [4:0]  meta_mem   [FRAME_DEPTH];

    state_t           state_reg, state_next;
    logic [3:0]       chcfg_reg;
    logic [CNT_W-1:0] capcfg_reg;
    logic [CNT_W-1:0] wi_reg, wi_next, ri_reg, ri_next;
    logic [CNT_W-1:0] used_reg, used_next, pend_reg, pend_next, peak_reg, peak_next;
    logic [CNT_W-1:0] plen_reg, plen_next, slot_reg, slot_next;
    logic [CHW-1:0]   pos_reg, pos_next, chan_reg, chan_next;
    logic             acc_reg, acc_next;
    fmt_t             pfmt_reg, pfmt_next;
    logic [2:0]       pflg_reg, pflg_next;

    logic [CHC_W-1:0] ch_eff;
    logic [CNT_W-1:0] cap_eff;
    logic             accept;
    logic             we;
    logic [CNT_W:0]   wslot_sum, sum;
    logic [CNT_W-1:0] wslot;
    logic [CHW-1:0]   wpos;
    logic [31:0]      rdata_reg;
    logic [4:0]       rmeta_reg;
    logic             pop_last;

    always_comb
    begin
        if (chcfg_reg == 4'd0)
            ch_eff = CHC_W'(1);
        else if (32'(chcfg_reg) > MAX_CHANNELS)
            ch_eff = CHC_W'(MAX_CHANNELS);
        else
            ch_eff = CHC_W'(chcfg_reg);
        if (capcfg_reg == '0)
            cap_eff = CNT_W'(1);
        else if (32'(capcfg_reg) > FRAME_DEPTH)
            cap_eff = CNT_W'(FRAME_DEPTH);
        else
            cap_eff = capcfg_reg;
    end

    assign in_ready = (state_reg == S_IDLE) && q_ready;
    assign accept   = in_valid && in_ready;
    assign pop_last = (CHC_W'(chan_reg) + CHC_W'(1)) == ch_eff;

    always_comb
    begin
        state_next = state_reg;
        wi_next    = wi_reg;
        ri_next    = ri_reg;
        used_next  = used_reg;
        pend_next  = pend_reg;
        peak_next  = peak_reg;
        plen_next  = plen_reg;
        slot_next  = slot_reg;
        pos_next   = pos_reg;
        chan_next  = chan_reg;
        acc_next   = acc_reg;
        pfmt_next  = pfmt_reg;
        pflg_next  = pflg_reg;
        we         = 1'b0;
        wslot      = '0;
        wpos       = '0;
        wslot_sum  = '0;
        sum        = '0;
        q_push     = 1'b0;
        q_data     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd)
                begin
                    if (used_reg == '0)
                    begin
                        q_push      = 1'b1;
                        q_data.kind = KIND_EMPTY;
                    end
                    else
                    begin
                        slot_next  = ri_reg;
                        ri_next    = (ri_reg + 1'b1 == cap_eff) ? '0 : ri_reg + 1'b1;
                        used_next  = used_reg - 1'b1;
                        chan_next  = '0;
                        state_next = S_RD;
                    end
                end
                else if (accept)
                begin
                    if (first)
                    begin
                        pend_next = '0;
                        pos_next  = '0;
                        q_push    = 1'b1;
                        if ((CNT_W+1)'(used_reg) + (CNT_W+1)'(plen) > (CNT_W+1)'(cap_eff))
                        begin
                            acc_next    = 1'b0;
                            q_data.kind = KIND_REJECT;
                        end
                        else
                        begin
                            acc_next    = 1'b1;
                            plen_next   = plen;
                            pfmt_next   = fmt_t'(fmt);
                            pflg_next   = flg;
                            q_data.kind = KIND_ACCEPT;
                        end
                    end
                    if (acc_next)
                    begin
                        if (pend_next < plen_next)
                        begin
                            wslot_sum = (CNT_W+1)'(wi_reg) + (CNT_W+1)'(pend_next);
                            wslot = (wslot_sum >= (CNT_W+1)'(cap_eff)) ?
                                    CNT_W'(wslot_sum - (CNT_W+1)'(cap_eff)) :
                                    CNT_W'(wslot_sum);
                            wpos = pos_next;
                            we = 1'b1;
                            if (CHC_W'(pos_next) + CHC_W'(1) >= ch_eff)
                            begin
                                pos_next  = '0;
                                pend_next = pend_next + 1'b1;
                            end
                            else
                            begin
                                pos_next = pos_next + 1'b1;
                            end
                        end
                        if (last)
                        begin
                            sum = (CNT_W+1)'(wi_reg) + (CNT_W+1)'(pend_next);
                            wi_next = (sum >= (CNT_W+1)'(cap_eff)) ?
                                      CNT_W'(sum - (CNT_W+1)'(cap_eff)) : CNT_W'(sum);
                            used_next = used_reg + pend_next;
                            if (used_next > peak_reg)
                                peak_next = used_next;
                            pend_next = '0;
                            pos_next  = '0;
                            acc_next  = 1'b0;
                        end
                    end
                end
                q_data.used = used_next;
                q_data.peak = peak_next;
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (q_ready)
                begin
                    q_push       = 1'b1;
                    q_data.kind  = KIND_POP;
                    q_data.raw   = rdata_reg;
                    q_data.fmt   = fmt_t'(rmeta_reg[4:3]);
                    q_data.flags = rmeta_reg[2:0];
                    q_data.last  = pop_last;
                    q_data.used  = used_reg;
                    q_data.peak  = peak_reg;
                    if (pop_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sample and frame stores, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            if (!pflg_next[0])
            begin
                sample_mem[AW'(wslot[IW-1:0]) * AW'(MAX_CHANNELS) + AW'(wpos)] <= raw;
            end
            meta_mem[wslot[IW-1:0]] <= {pfmt_next, pflg_next};
        end
        rdata_reg <= sample_mem[AW'(slot_reg[IW-1:0]) * AW'(MAX_CHANNELS) + AW'(chan_reg)];
        rmeta_reg <= meta_mem[slot_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            chcfg_reg  <= CH_RESET;
            capcfg_reg <= CAP_RESET;
            wi_reg     <= '0;
            ri_reg     <= '0;
            used_reg   <= '0;
            pend_reg   <= '0;
            peak_reg   <= '0;
            plen_reg   <= '0;
            slot_reg   <= '0;
            pos_reg    <= '0;
            chan_reg   <= '0;
            acc_reg    <= 1'b0;
            pfmt_reg   <= FMT_PCM16;
            pflg_reg   <= '0;
        end
        else if (cfg_we && (cfg_idx == REG_CHANNELS || cfg_idx == REG_CAPACITY))
        begin
            if (cfg_idx == REG_CHANNELS)
                chcfg_reg <= cfg_val[3:0];
            else
                capcfg_reg <= cfg_val;
            wi_reg   <= '0;
            ri_reg   <= '0;
            used_reg <= '0;
            pend_reg <= '0;
            pos_reg  <= '0;
            acc_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wi_reg    <= wi_next;
            ri_reg    <= ri_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            peak_reg  <= peak_next;
            plen_reg  <= plen_next;
            slot_reg  <= slot_next;
            pos_reg   <= pos_next;
            chan_reg  <= chan_next;
            acc_reg   <= acc_next;
            pfmt_reg  <= pfmt_next;
            pflg_reg  <= pflg_next;
        end
    end
endmodule
`default_nettype wire

>>> design/afr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module afr_back
    import afr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  job_t      q_data,
    input  wire logic q_valid,
    output logic      q_pop,
    output res_t      res,
    output logic      res_valid,
    input  wire logic res_ready
);
    typedef enum logic [1:0] { B_IDLE, B_NORM, B_OUT } state_t;

    state_t      state_reg;
    res_t        res_reg;
    logic [31:0] mag_reg;
    logic [4:0]  p_reg;
    logic [7:0]  ebias_reg;
    logic        sign_reg;

    logic [31:0] v, mag;
    logic [7:0]  ebias;
    logic [24:0] keep;
    logic [7:0]  rem;
    logic [7:0]  expo;

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign res_valid = (state_reg == B_OUT);
    assign res       = res_reg;

    always_comb
    begin
        case (q_data.fmt)
            FMT_PCM16: begin v = {{16{q_data.raw[15]}}, q_data.raw[15:0]}; ebias = 8'd112; end
            FMT_PCM24: begin v = {{8{q_data.raw[23]}}, q_data.raw[23:0]};  ebias = 8'd104; end
            default:   begin v = q_data.raw;                                ebias = 8'd96;  end
        endcase
        mag = v[31] ? (32'd0 - v) : v;
        // normalized: bits below the 24-bit mantissa round to nearest, ties to even
        rem  = mag_reg[7:0];
        keep = {1'b0, mag_reg[31:8]};
        if (rem > 8'h80 || (rem == 8'h80 && keep[0]))
            keep = keep + 25'd1;
        expo = 8'(p_reg) + ebias_reg;
        if (keep[24])
        begin
            keep = keep >> 1;
            expo = expo + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            res_reg   <= '0;
            mag_reg   <= '0;
            p_reg     <= '0;
            ebias_reg <= '0;
            sign_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        res_reg.kind   <= q_data.kind;
                        res_reg.flags  <= q_data.flags;
                        res_reg.last   <= q_data.last;
                        res_reg.used   <= q_data.used;
                        res_reg.peak   <= q_data.peak;
                        if (q_data.kind == KIND_POP && !q_data.flags[0] &&
                            q_data.fmt != FMT_FLT32 && mag != '0)
                        begin
                            res_reg.sample <= '0;
                            mag_reg        <= mag;
                            p_reg          <= 5'd31;
                            ebias_reg      <= ebias;
                            sign_reg       <= v[31];
                            state_reg      <= B_NORM;
                        end
                        else
                        begin
                            if (q_data.kind == KIND_POP && !q_data.flags[0] &&
                                q_data.fmt == FMT_FLT32)
                                res_reg.sample <= q_data.raw;
                            else
                                res_reg.sample <= '0;
                            state_reg <= B_OUT;
                        end
                    end
                end
                B_NORM:
                begin
                    if (mag_reg[31:24] == 8'd0)
                    begin
                        mag_reg <= mag_reg << 8;
                        p_reg   <= p_reg - 5'd8;
                    end
                    else if (!mag_reg[31])
                    begin
                        mag_reg <= mag_reg << 1;
                        p_reg   <= p_reg - 5'd1;
                    end
                    else
                    begin
                        res_reg.sample <= {sign_reg, expo, keep[22:0]};
                        state_reg      <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (res_ready)
                        state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/audio_frame_ring_pcm_to_float.sv
`timescale 1ns / 1ps
`default_nettype none
// Ring of multichannel audio frames with PCM-to-float conversion on read.
// s_axis: requests. tuser[0] command (0 push sample, 1 pop frame), tuser[1] first
//   of packet, tlast last of packet. A push is taken whenever the front is idle and
//   the queue has room; the first sample of a packet yields an accept/reject result.
//   A pop reads each channel once through the single read port, then queues it.
// m_axis: results, tuser result kind, tlast last channel of a popped frame.
// cfg: writes channel count (index 0) or ring capacity (index 1); clears the ring.
// Each result passes the converter's capture and output states; nonzero PCM samples
// also pass a normalize state. A four-entry queue separates request handling from
// conversion, so pushes keep being taken while m_axis is stalled, until the queue fills.
// Reset empties the ring and peak level; stores are not cleared and need no sweep.
module audio_frame_ring_pcm_to_float
    import afr_pkg::*;
#(
    parameter int FRAME_DEPTH  = 1024,
    parameter int MAX_CHANNELS = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // sample_raw[31:0], sample_format[33:32], buffer_flags[36:34], packet_frames[47:37]
    input  wire logic [47:0]      s_tdata,
    // command[0], first_of_packet[1]
    input  wire logic [1:0]       s_tuser,
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // sample_out[31:0], frame_flags[34:32], used_frames[45:35], peak_used[56:46], zeros
    output logic [63:0]           m_tdata,
    // result_kind[1:0]
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);
    logic q_push, q_ready, q_pop, q_valid;
    job_t q_in, q_out;
    res_t res;

    assign cfg_ready = 1'b1;

    afr_front #(.FRAME_DEPTH(FRAME_DEPTH), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid),
        .cfg_idx  (cfg_index),
        .cfg_val  (cfg_data),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (s_tuser[0]),
        .raw      (s_tdata[31:0]),
        .fmt      (s_tdata[33:32]),
        .flg      (s_tdata[36:34]),
        .plen     (s_tdata[47:37]),
        .first    (s_tuser[1]),
        .last     (s_tlast),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_ready  (q_ready)
    );

    afr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_out),
        .pop_valid  (q_valid)
    );

    afr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_out),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .res       (res),
        .res_valid (m_tvalid),
        .res_ready (m_tready)
    );

    assign m_tdata = {7'd0, res.peak, res.used, res.flags, res.sample};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule
`default_nettype wire

>>> tb/tb_audio_frame_ring_pcm_to_float.sv
`timescale 1ns / 1ps
module tb_audio_frame_ring_pcm_to_float;
    import afr_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_ITEMS = 210;
    localparam bit CMD_PUSH = 1'b0;
    localparam bit CMD_POP  = 1'b1;

    // frame ring predictor and queue of expected results
    class ring_scoreboard;
        res_t        expected[$];
        int          errors;
        logic [31:0] samples[0:8191];
        logic [2:0]  frame_flags[0:1023];
        fmt_t        frame_fmt[0:1023];
        int unsigned wr_idx, rd_idx, used, pending, chpos, peak;
        bit          open;
        int unsigned pkt_len;
        fmt_t        pkt_fmt;
        logic [2:0]  pkt_flags;
        logic [3:0]  ch_reg;
        logic [10:0] cap_reg;

        function new();
            ch_reg = CH_RESET;
            cap_reg = CAP_RESET;
            errors = 0;
            peak = 0;
            pkt_len = 0;
            pkt_fmt = FMT_PCM16;
            pkt_flags = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            wr_idx = 0; rd_idx = 0; used = 0; pending = 0; chpos = 0; open = 0;
        endfunction

        function int unsigned channels();
            if (ch_reg == 0) return 1;
            if (ch_reg > 8) return 8;
            return ch_reg;
        endfunction

        function int unsigned capacity();
            if (cap_reg == 0) return 1;
            if (cap_reg > 1024) return 1024;
            return cap_reg;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] val);
            if (idx == REG_CHANNELS) ch_reg = val[3:0];
            else if (idx == REG_CAPACITY) cap_reg = val;
            else return;
            clear_ring();
        endfunction

        // v * 2^-shift as single precision, nearest even
        function logic [31:0] scale_to_float(logic [31:0] v, int unsigned shift);
            logic [31:0] mag, keep, rem, half;
            int unsigned p, drop;
            logic [7:0] e;
            mag = v[31] ? (32'd0 - v) : v;
            if (mag == 0) return 32'd0;
            p = 0;
            while (p < 31 && (mag >> (p + 1)) != 0) p++;
            if (p <= 23) begin
                keep = mag << (23 - p);
            end else begin
                drop = p - 23;
                rem = mag & ((32'd1 << drop) - 1);
                half = 32'd1 << (drop - 1);
                keep = mag >> drop;
                if (rem > half || (rem == half && keep[0])) keep++;
                if (keep == (32'd1 << 24)) begin
                    keep = keep >> 1;
                    p++;
                end
            end
            e = 8'(p + 127 - shift);
            return {v[31], e, keep[22:0]};
        endfunction

        function logic [31:0] to_float(logic [31:0] raw, fmt_t f);
            case (f)
                FMT_PCM16: return scale_to_float({{16{raw[15]}}, raw[15:0]}, 15);
                FMT_PCM24: return scale_to_float({{8{raw[23]}}, raw[23:0]}, 23);
                FMT_PCM32: return scale_to_float(raw, 31);
                default:   return raw;
            endcase
        endfunction

        function void add(kind_t k, logic [31:0] s, logic [2:0] fl, logic lst);
            res_t r;
            r.kind = k; r.sample = s; r.flags = fl; r.last = lst;
            r.used = used[10:0]; r.peak = peak[10:0];
            expected.insert(expected.size(), r);
        endfunction

        function void note_request(bit cmd, logic [31:0] raw, fmt_t f, logic [2:0] fl,
                                   logic [10:0] plen, bit first, bit lst);
            int unsigned ch, cap, slot, pos;
            ch = channels();
            cap = capacity();
            if (cmd == CMD_POP) begin
                if (used == 0) begin
                    add(KIND_EMPTY, 0, 0, 0);
                    return;
                end
                slot = rd_idx % cap;
                rd_idx = (slot + 1) % cap;
                used--;
                for (int c = 0; c < ch; c++)
                    add(KIND_POP, frame_flags[slot][0] ? 32'd0 :
                        to_float(samples[slot * 8 + c], frame_fmt[slot]),
                        frame_flags[slot], c + 1 == ch);
                return;
            end
            if (first) begin
                pending = 0;
                chpos = 0;
                if (used + plen > cap) begin
                    open = 0;
                    add(KIND_REJECT, 0, 0, 0);
                    return;
                end
                open = 1;
                pkt_len = plen; pkt_fmt = f; pkt_flags = fl;
            end
            if (open) begin
                if (pending < pkt_len) begin
                    slot = (wr_idx % cap + pending) % cap;
                    pos = chpos % ch;
                    if (!pkt_flags[0]) samples[slot * 8 + pos] = raw;
                    frame_flags[slot] = pkt_flags;
                    frame_fmt[slot] = pkt_fmt;
                    if (pos + 1 >= ch) begin
                        chpos = 0;
                        pending++;
                    end else begin
                        chpos = pos + 1;
                    end
                end
                if (lst) begin
                    wr_idx = (wr_idx % cap + pending) % cap;
                    used += pending;
                    if (used > peak) peak = used;
                    pending = 0; chpos = 0; open = 0;
                end
            end
            // accept status carries the fill level after a same-cycle commit
            if (first) add(KIND_ACCEPT, 0, 0, 0);
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            if (expected.size() == 0) begin
                $display("%0t: unexpected result kind=%0d sample=%h", $time, got.kind,
                         got.sample);
                errors++;
                return;
            end
            exp_r = expected.pop_front();
            if (got != exp_r) begin
                $display("%0t: mismatch expected kind=%0d sample=%h flags=%0d last=%0d used=%0d peak=%0d",
                         $time, exp_r.kind, exp_r.sample, exp_r.flags, exp_r.last,
                         exp_r.used, exp_r.peak);
                $display("%0t:          actual kind=%0d sample=%h flags=%0d last=%0d used=%0d peak=%0d",
                         $time, got.kind, got.sample, got.flags, got.last, got.used,
                         got.peak);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    ring_scoreboard ring;
    res_t           got;
    int             cycles;
    int             stall_left;
    int             sent;
    bit             no_gaps;

    audio_frame_ring_pcm_to_float dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("audio_frame_ring_pcm_to_float test failed");
            $finish;
        end
    end

    // result-side backpressure: mostly ready, short stalls, a few long ones
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!no_gaps && $urandom_range(0, 99) < 12)
        begin
            m_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // handshake completes at the coming edge; inputs only move at rising edges
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind   = kind_t'(m_tuser);
            got.sample = m_tdata[31:0];
            got.flags  = m_tdata[34:32];
            got.used   = m_tdata[45:35];
            got.peak   = m_tdata[56:46];
            got.last   = m_tlast;
            ring.check_result(got);
        end
    end

    function int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send(bit cmd, logic [31:0] raw, fmt_t f, logic [2:0] fl,
                        logic [10:0] plen, bit first, bit lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {plen, fl, f, raw};
        s_tuser  <= {first, cmd};
        s_tlast  <= lst;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        ring.note_request(cmd, raw, f, fl, plen, first, lst);
        sent++;
        @(posedge clk);
    endtask

    task automatic push(logic [31:0] raw, fmt_t f, logic [2:0] fl, logic [10:0] plen,
                        bit first, bit lst);
        send(CMD_PUSH, raw, f, fl, plen, first, lst);
    endtask

    task automatic pop_frame();
        send(CMD_POP, $urandom, fmt_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
             11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (ring.expected.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        ring.write_reg(idx, val);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one packet: mostly well formed, some cut short, overrun or abandoned
    task automatic random_packet();
        int unsigned ch, plen, n, style;
        fmt_t        f;
        logic [2:0]  fl;
        logic [31:0] raw;
        ch = ring.channels();
        f = fmt_t'($urandom_range(0, 3));
        fl = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(0, 3) << 1);
        case ($urandom_range(0, 9))
            0:       plen = $urandom_range(0, 2047);
            1:       plen = ring.capacity() - ring.used + $urandom_range(0, 2);
            default: plen = $urandom_range(0, 3);
        endcase
        plen = plen & 11'h7ff;
        style = $urandom_range(0, 19);
        n = plen * ch;
        if (n == 0) n = 1;
        if (style == 0) n = n + $urandom_range(1, 3);
        else if (style == 1 && n > 1) n = $urandom_range(1, n - 1);
        if (n > 14) n = 14;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0:       raw = {$urandom_range(0, 1) ? 17'h1ffff : 17'h0, 15'($urandom)};
                1:       raw = {32{1'b1}} ^ $urandom;
                default: raw = $urandom;
            endcase
            // later samples carry noise in the fields that only the first one uses
            push(raw, i == 0 ? f : fmt_t'($urandom_range(0, 3)),
                 i == 0 ? fl : 3'($urandom_range(0, 7)),
                 i == 0 ? 11'(plen) : 11'($urandom_range(0, 2047)),
                 i == 0, (i == n - 1) && style != 2);
        end
    endtask

    task automatic random_phase(int items);
        int stop;
        stop = sent + items;
        while (sent < stop)
        begin
            if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
            case ($urandom_range(0, 9))
                0, 1, 2: pop_frame();
                3:       push($urandom, fmt_t'($urandom_range(0, 3)),
                              3'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)),
                              1'b0, 1'($urandom_range(0, 1)));
                default: random_packet();
            endcase
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        ring = new();
        cycles = 0;
        stall_left = 0;
        sent = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CHANNELS;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, two channels and full ring from reset
        pop_frame();
        push(32'h0000_8000, FMT_PCM16, 3'd0, 11'd2, 1'b1, 1'b0);
        push(32'h0000_7fff, FMT_PCM16, 3'd5, 11'd9, 1'b0, 1'b0);
        push(32'h0000_0001, FMT_PCM16, 3'd0, 11'd0, 1'b0, 1'b0);
        push(32'hffff_0000, FMT_PCM16, 3'd0, 11'd0, 1'b0, 1'b1);
        push(32'h0080_0000, FMT_PCM24, 3'd2, 11'd1, 1'b1, 1'b0);
        push(32'h007f_ffff, FMT_PCM24, 3'd0, 11'd0, 1'b0, 1'b1);
        push(32'h8000_0000, FMT_PCM32, 3'd6, 11'd1, 1'b1, 1'b0);
        push(32'h7fff_ffff, FMT_PCM32, 3'd0, 11'd0, 1'b0, 1'b1);
        push(32'hffff_ffff, FMT_FLT32, 3'd0, 11'd1, 1'b1, 1'b0);
        push(32'h0000_0001, FMT_FLT32, 3'd0, 11'd0, 1'b0, 1'b1);
        push(32'h0000_1234, FMT_PCM16, 3'd7, 11'd1, 1'b1, 1'b0);
        push(32'h0000_5678, FMT_PCM16, 3'd0, 11'd0, 1'b0, 1'b1);
        push(32'h1111_1111, FMT_PCM32, 3'd0, 11'd0, 1'b1, 1'b1);
        push(32'h0000_0123, FMT_PCM32, 3'd0, 11'd3, 1'b1, 1'b0);
        push(32'h8000_0001, FMT_PCM32, 3'd0, 11'd0, 1'b0, 1'b0);
        push(32'h0000_0456, FMT_PCM32, 3'd0, 11'd0, 1'b0, 1'b1);
        push(32'h00ff_ffff, FMT_PCM24, 3'd0, 11'd2047, 1'b1, 1'b0);
        push(32'h0000_0002, FMT_PCM24, 3'd0, 11'd0, 1'b0, 1'b1);
        push(32'h0000_4000, FMT_PCM16, 3'd0, 11'd2, 1'b1, 1'b0);
        push(32'h0000_c000, FMT_PCM16, 3'd1, 11'd1, 1'b1, 1'b0);
        push(32'h0000_0003, FMT_PCM16, 3'd0, 11'd0, 1'b0, 1'b0);
        push(32'h0000_0004, FMT_PCM16, 3'd0, 11'd0, 1'b0, 1'b1);
        repeat (9) pop_frame();

        random_phase(25);
        write_reg(REG_CHANNELS, 11'd8);
        write_reg(REG_CAPACITY, 11'd4);
        random_phase(30);
        write_reg(REG_CHANNELS, 11'd1);
        write_reg(REG_CAPACITY, 11'd1);
        random_phase(25);
        write_reg(REG_CHANNELS, 11'h7f0);
        write_reg(REG_CAPACITY, 11'd0);
        random_phase(25);
        write_reg(REG_CHANNELS, 11'h00f);
        write_reg(REG_CAPACITY, 11'h7ff);
        random_phase(30);
        write_reg(REG_CHANNELS, 11'd3);
        write_reg(REG_CAPACITY, 11'd6);
        random_phase(25);

        drain();
        if (ring.errors == 0 && ring.expected.size() == 0)
        begin
            $display("audio_frame_ring_pcm_to_float test passed");
        end
        else
        begin
            $display("audio_frame_ring_pcm_to_float test failed");
        end
        $finish;
    end

endmodule
